### rtl/rfl_pkg.sv
package rfl_pkg;

  localparam logic [7:0] StxByte   = 8'h02;
  localparam logic [7:0] WriteByte = 8'h37;
  localparam logic [7:0] ReadByte  = 8'h38;
  localparam logic [7:0] AckByte   = 8'h06;
  localparam logic [7:0] NackByte  = 8'h15;
  localparam logic [7:0] CountByte = 8'h01;

  localparam logic [7:0] AckSum  = 8'(StxByte + WriteByte + AckByte);
  localparam logic [7:0] NackSum = 8'(StxByte + WriteByte + NackByte);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACK       = 3'd0,
    ST_NACK      = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_SUM_ERR   = 3'd4,
    ST_HEAD_ERR  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    JOB_READ   = 2'd0,
    JOB_WRITE  = 2'd1,
    JOB_REPORT = 2'd2
  } job_e;

  // One unit of work for the transmit side: a request frame or a reply report.
  typedef struct packed {
    job_e       kind;
    logic [7:0] addr;
    logic [7:0] data;    // write value, or read value of a report
    status_e    status;
  } job_t;

endpackage

### rtl/register_frame_link_host_top.sv
// Host side of a byte-framed register link. Input transfers carry a read
// request, a write request or one received reply byte (tuser selects which).
// A read request yields five transmit transfers and a write request six, the
// last one flagged by tlast and holding the 8-bit additive sum; the fourth
// reply byte after a request yields one report transfer (tuser high) with
// the reply status and read value, and other reply bytes yield nothing. The
// receiver is classified on input, so an input transfer is taken every cycle
// while the job queue has room. The single output port sends one transfer
// per cycle while m_axis_tready is high; a request takes five or six
// transfers and a report one. Each job passes through the queue and then
// the output register. QueueDepth jobs can wait between the two sides.
module register_frame_link_host_top #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // reg_addr, wr_value, rx_byte
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tx_byte, reply_status, read_value, zero pad
  output logic        m_axis_tlast,   // tx_last
  output logic        m_axis_tuser    // out_kind
);
  import rfl_pkg::*;

  logic full, push, pop, job_valid;
  job_t push_job, head_job;

  rfl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  rfl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (head_job)
  );

  rfl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/rfl_front.sv
module rfl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // reg_addr, wr_value, rx_byte
  input  logic [1:0]    s_axis_tuser,   // command
  input  logic          full_i,
  output logic          push_o,
  output rfl_pkg::job_t job_o
);
  import rfl_pkg::*;

  logic       pending_q, pending_d;
  logic       expect_rd_q, expect_rd_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] hdr_q [3];

  logic       accept;
  logic [7:0] reg_addr, wr_value, rx_byte;
  logic       head_wr, hdr_wr;
  status_e    status;
  logic [7:0] value;

  assign reg_addr = s_axis_tdata[7:0];
  assign wr_value = s_axis_tdata[15:8];
  assign rx_byte  = s_axis_tdata[23:16];

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Judge the final reply byte against the gathered header.
  always_comb begin
    head_wr = (hdr_q[0] == StxByte) && (hdr_q[1] == WriteByte);
    value   = '0;
    if (expect_rd_q) begin
      if (rx_byte != sum_q) begin
        status = ST_SUM_ERR;
      end else if (hdr_q[0] != StxByte || hdr_q[1] != ReadByte) begin
        status = ST_HEAD_ERR;
      end else begin
        status = ST_READ_OK;
        value  = hdr_q[2];
      end
    end else if (head_wr && hdr_q[2] == AckByte && rx_byte == AckSum) begin
      status = ST_ACK;
    end else if (head_wr && hdr_q[2] == NackByte && rx_byte == NackSum) begin
      status = ST_NACK;
    end else begin
      status = ST_UNKNOWN;
    end
  end

  always_comb begin
    pending_d   = pending_q;
    expect_rd_d = expect_rd_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    hdr_wr      = 1'b0;
    push_o      = 1'b0;
    job_o.kind   = JOB_REPORT;
    job_o.addr   = reg_addr;
    job_o.data   = wr_value;
    job_o.status = status;
    if (accept) begin
      case (cmd_e'(s_axis_tuser))
        CMD_READ, CMD_WRITE: begin
          push_o      = 1'b1;
          job_o.kind  = (cmd_e'(s_axis_tuser) == CMD_WRITE) ? JOB_WRITE : JOB_READ;
          pending_d   = 1'b1;
          expect_rd_d = (cmd_e'(s_axis_tuser) == CMD_READ);
          pos_d       = '0;
          sum_d       = '0;
        end
        CMD_RX: begin
          if (pending_q) begin
            if (pos_q != 2'd3) begin
              hdr_wr = 1'b1;
              sum_d  = sum_q + rx_byte;
              pos_d  = pos_q + 2'd1;
            end else begin
              push_o     = 1'b1;
              job_o.data = value;
              pending_d  = 1'b0;
              pos_d      = '0;
              sum_d      = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      expect_rd_q <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
    end else begin
      pending_q   <= pending_d;
      expect_rd_q <= expect_rd_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_wr) begin
      hdr_q[pos_q] <= rx_byte;
    end
  end

endmodule

### rtl/rfl_queue.sv
module rfl_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rfl_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rfl_pkg::job_t data_o
);
  import rfl_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count missed a write");
`endif

endmodule

### rtl/rfl_back.sv
module rfl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  rfl_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,   // tx_byte, reply_status, read_value, zero pad
  output logic          m_axis_tlast,   // tx_last
  output logic          m_axis_tuser    // out_kind
);
  import rfl_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] step_q, step_d;
  logic [7:0] sum_q, sum_d;
  job_t       job_q, job_d;

  logic        valid_q, valid_d;
  logic [23:0] data_q, data_d;
  logic        last_q, last_d;
  logic        kind_q, kind_d;

  job_t       cur;
  logic [2:0] step;
  logic [7:0] sum;
  logic       fire;
  logic       done;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       is_wr;

  always_comb begin
    cur     = busy_q ? job_q : job_i;
    step    = busy_q ? step_q : '0;
    sum     = busy_q ? sum_q : '0;
    fire    = (busy_q || job_valid_i) && (!valid_q || m_axis_tready);
    is_wr   = (cur.kind == JOB_WRITE);
    tx_byte = '0;
    tx_last = 1'b0;
    done    = 1'b1;
    if (cur.kind != JOB_REPORT) begin
      case (step)
        3'd0:    tx_byte = StxByte;
        3'd1:    tx_byte = is_wr ? WriteByte : ReadByte;
        3'd2:    tx_byte = cur.addr;
        3'd3:    tx_byte = CountByte;
        3'd4:    tx_byte = is_wr ? cur.data : sum;
        default: tx_byte = sum;
      endcase
      tx_last = is_wr ? (step == 3'd5) : (step == 3'd4);
      done    = tx_last;
    end
  end

  assign job_pop_o = fire && !busy_q;

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    sum_d   = sum_q;
    job_d   = job_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    kind_d  = kind_q;
    if (fire) begin
      valid_d = 1'b1;
      last_d  = tx_last;
      if (cur.kind == JOB_REPORT) begin
        kind_d = 1'b1;
        data_d = {5'd0, cur.data, cur.status, 8'd0};
      end else begin
        kind_d = 1'b0;
        data_d = {16'd0, tx_byte};
      end
      // Advance through the frame, or release the job on its final transfer.
      busy_d = !done;
      step_d = step + 3'd1;
      sum_d  = sum + tx_byte;
      job_d  = cur;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    job_q  <= job_d;
    data_q <= data_d;
    last_q <= last_d;
    kind_q <= kind_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = kind_q;

`ifndef NO_ASSERTIONS
  a_busy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q != 3'd0 && job_q.kind != JOB_REPORT))
    else $error("frame in progress with bad step or job kind");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= 3'd5))
    else $error("frame step beyond sum byte");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> !busy_q)
    else $error("job taken while frame in progress");
`endif

endmodule
